[design/clkal_pkg.sv]
// ----------------------------------------------------------------------------
// Clock set and alarm controller package
// Shared types, codes, constants and digit helpers for the clock controller.
// ----------------------------------------------------------------------------
`default_nettype none

package clkal_pkg;

   // Operation codes of an input item.
   typedef enum logic [2:0] {
      OP_SAMPLE    = 3'd0,
      OP_MENU      = 3'd1,
      OP_NEXT      = 3'd2,
      OP_INCREMENT = 3'd3,
      OP_DECREMENT = 3'd4
   } op_type;

   // Edit mode, one-hot inside the block.
   typedef enum logic [2:0] {
      MODE_IDLE  = 3'b001,
      MODE_TIME  = 3'b010,
      MODE_ALARM = 3'b100
   } mode_type;

   // Edit mode codes as seen on the result channel.
   localparam logic [1:0] EDIT_IDLE  = 2'd0;
   localparam logic [1:0] EDIT_TIME  = 2'd1;
   localparam logic [1:0] EDIT_ALARM = 2'd2;

   // Beep codes.
   localparam logic [2:0] BEEP_NONE  = 3'd0;
   localparam logic [2:0] BEEP_ONE   = 3'd1;
   localparam logic [2:0] BEEP_TWO   = 3'd2;
   localparam logic [2:0] BEEP_FOUR  = 3'd3;
   localparam logic [2:0] BEEP_ALARM = 3'd4;

   // Configuration register indexes and reset values.
   localparam logic CSR_SHORT_LIMIT = 1'b0;
   localparam logic CSR_LONG_LIMIT  = 1'b1;
   localparam logic [31:0] SHORT_LIMIT_RESET = 32'd1030000;
   localparam logic [31:0] LONG_LIMIT_RESET  = 32'd4090000;

   // Time bounds.
   localparam logic [4:0] MAX_HOURS   = 5'd23;
   localparam logic [5:0] MAX_MINUTES = 6'd59;

   // Cursor positions.
   localparam logic [2:0] CURSOR_HOUR_TENS   = 3'd1;
   localparam logic [2:0] CURSOR_HOUR_UNITS  = 3'd2;
   localparam logic [2:0] CURSOR_MIN_TENS    = 3'd3;
   localparam logic [2:0] CURSOR_MIN_UNITS   = 3'd4;

   // One result item.
   typedef struct packed {
      logic [31:0] display_word;
      logic        display_valid;
      logic [2:0]  beep_code;
      logic        rtc_write;
      logic [4:0]  set_hours;
      logic [5:0]  set_minutes;
      logic [1:0]  edit_mode;
      logic [2:0]  cursor_digit;
   } result_type;

   // Seven-segment code of one decimal digit.
   function automatic logic [7:0] seg_code(input logic [3:0] digit);
      logic [7:0] code;
      case (digit)
         4'd0:    code = 8'hFC;
         4'd1:    code = 8'h30;
         4'd2:    code = 8'h6E;
         4'd3:    code = 8'h7A;
         4'd4:    code = 8'hB2;
         4'd5:    code = 8'hDA;
         4'd6:    code = 8'hDE;
         4'd7:    code = 8'h70;
         4'd8:    code = 8'hFE;
         4'd9:    code = 8'hFA;
         default: code = 8'h00;
      endcase
      return code;
   endfunction

   // Tens digit of an hour value up to 29.
   function automatic logic [1:0] hour_tens_of(input logic [4:0] hours);
      logic [1:0] tens;
      if (hours >= 5'd20) begin
         tens = 2'd2;
      end else if (hours >= 5'd10) begin
         tens = 2'd1;
      end else begin
         tens = 2'd0;
      end
      return tens;
   endfunction

   // Units digit of an hour value up to 29.
   function automatic logic [3:0] hour_units_of(input logic [4:0] hours);
      logic [1:0] tens;
      logic [4:0] rest;
      tens = hour_tens_of(hours);
      rest = hours - ({tens, 3'b000} + {2'b00, tens, 1'b0});
      return rest[3:0];
   endfunction

   // Tens digit of a minute value up to 63.
   function automatic logic [2:0] minute_tens_of(input logic [5:0] minutes);
      logic [2:0] tens;
      if (minutes >= 6'd60) begin
         tens = 3'd6;
      end else if (minutes >= 6'd50) begin
         tens = 3'd5;
      end else if (minutes >= 6'd40) begin
         tens = 3'd4;
      end else if (minutes >= 6'd30) begin
         tens = 3'd3;
      end else if (minutes >= 6'd20) begin
         tens = 3'd2;
      end else if (minutes >= 6'd10) begin
         tens = 3'd1;
      end else begin
         tens = 3'd0;
      end
      return tens;
   endfunction

   // Units digit of a minute value up to 63.
   function automatic logic [3:0] minute_units_of(input logic [5:0] minutes);
      logic [2:0] tens;
      logic [5:0] rest;
      tens = minute_tens_of(minutes);
      rest = minutes - ({tens, 3'b000} + {2'b00, tens, 1'b0});
      return rest[3:0];
   endfunction

   // Four segment bytes for a time; the hour tens byte is blank below 10.
   function automatic logic [31:0] make_word(input logic [4:0] hours,
                                             input logic [5:0] minutes);
      logic [4:0] h;
      logic [5:0] m;
      logic [7:0] top;
      h = (hours > MAX_HOURS) ? MAX_HOURS : hours;
      m = (minutes > MAX_MINUTES) ? MAX_MINUTES : minutes;
      top = (h >= 5'd10) ? seg_code({2'b00, hour_tens_of(h)}) : 8'h00;
      return {top, seg_code(hour_units_of(h)),
              seg_code({1'b0, minute_tens_of(m)}), seg_code(minute_units_of(m))};
   endfunction

   // Result channel code of an edit mode.
   function automatic logic [1:0] mode_code(input mode_type mode);
      logic [1:0] code;
      case (mode)
         MODE_TIME:  code = EDIT_TIME;
         MODE_ALARM: code = EDIT_ALARM;
         default:    code = EDIT_IDLE;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

[design/clkal_if.sv]
// ----------------------------------------------------------------------------
// Clock set and alarm controller channels
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

// Request channel: time samples and button events.
interface clkal_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  operation;
   logic [4:0]  rtc_hours;
   logic [5:0]  rtc_minutes;
   logic [5:0]  rtc_seconds;
   logic [31:0] press_length;

   modport source (
      output valid, operation, rtc_hours, rtc_minutes, rtc_seconds, press_length,
      input  ready
   );
   modport sink (
      input  valid, operation, rtc_hours, rtc_minutes, rtc_seconds, press_length,
      output ready
   );
endinterface

// Result channel: display word, beep and clock write request.
interface clkal_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] display_word;
   logic        display_valid;
   logic [2:0]  beep_code;
   logic        rtc_write;
   logic [4:0]  set_hours;
   logic [5:0]  set_minutes;
   logic [1:0]  edit_mode;
   logic [2:0]  cursor_digit;

   modport source (
      output valid, display_word, display_valid, beep_code, rtc_write,
             set_hours, set_minutes, edit_mode, cursor_digit,
      input  ready
   );
   modport sink (
      input  valid, display_word, display_valid, beep_code, rtc_write,
             set_hours, set_minutes, edit_mode, cursor_digit,
      output ready
   );
endinterface

`default_nettype wire

[design/clock_set_and_alarm_controller.sv]
// ----------------------------------------------------------------------------
// Clock set and alarm controller
// Turns clock samples and button events into display words, beeps and clock
// write requests, and runs the time and alarm edit menus.
// ----------------------------------------------------------------------------
// Usage:
// Request items enter on req_chan (valid/ready); each one gives exactly one
// result item on rsp_chan. An item is taken into an input register, then the
// decision logic updates the clock state and loads the result register once
// that register is free or being taken.
// Throughput is one item per clock while rsp_chan is not stalled: a new item
// enters the input register in the same cycle that the previous one leaves it.
// When the receiver stalls, the result register holds its item, the input
// register holds the next one, and req_chan.ready falls once both are full.
// Press limits are written via csr_write_enable, csr_index and csr_write_data,
// one register per clock edge, while no item is in flight (left to the user).
// Reset (synchronous, active high) empties both registers, returns the
// menu to idle with the cursor on the hour tens digit, clears the digits and
// the alarm, shows 22:22 as the last time, and restores the default limits.
// ----------------------------------------------------------------------------
`default_nettype none

module clock_set_and_alarm_controller
   import clkal_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   clkal_req_if.sink        req_chan,
   clkal_rsp_if.source      rsp_chan,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_write_data
);

   // Configuration registers.
   logic [31:0] short_limit_ff;
   logic [31:0] long_limit_ff;

   // Input register.
   logic        in_valid_ff;
   logic [2:0]  in_op_ff;
   logic [4:0]  in_hours_ff;
   logic [5:0]  in_minutes_ff;
   logic [5:0]  in_seconds_ff;
   logic [31:0] in_press_ff;

   // Result register.
   logic        out_valid_ff;
   result_type  out_ff;
   result_type  out_in;

   // Clock state.
   mode_type    mode_ff, mode_in;
   logic [2:0]  cursor_ff, cursor_in;
   logic [1:0]  hour_tens_ff, hour_tens_in;
   logic [3:0]  hour_units_ff, hour_units_in;
   logic [2:0]  minute_tens_ff, minute_tens_in;
   logic [3:0]  minute_units_ff, minute_units_in;
   logic [4:0]  alarm_hour_ff, alarm_hour_in;
   logic [5:0]  alarm_minute_ff, alarm_minute_in;
   logic        alarm_enabled_ff, alarm_enabled_in;
   logic [5:0]  last_second_ff, last_second_in;
   logic [4:0]  shown_hours_ff, shown_hours_in;
   logic [5:0]  shown_minutes_ff, shown_minutes_in;

   logic        advance;
   logic        accept;
   logic [4:0]  sample_hours;
   logic [5:0]  sample_minutes;
   logic [4:0]  edit_hours;
   logic [5:0]  edit_minutes;

   // Handshake: the input register moves on when the result register is free.
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         short_limit_ff <= SHORT_LIMIT_RESET;
         long_limit_ff  <= LONG_LIMIT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SHORT_LIMIT: short_limit_ff <= csr_write_data;
            CSR_LONG_LIMIT:  long_limit_ff  <= csr_write_data;
            default:         short_limit_ff <= short_limit_ff;
         endcase
      end
   end

   // Input register: valid bit and payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (accept) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_op_ff      <= req_chan.operation;
         in_hours_ff   <= req_chan.rtc_hours;
         in_minutes_ff <= req_chan.rtc_minutes;
         in_seconds_ff <= req_chan.rtc_seconds;
         in_press_ff   <= req_chan.press_length;
      end
   end

   // Saturated clock sample.
   assign sample_hours   = (in_hours_ff > MAX_HOURS) ? MAX_HOURS : in_hours_ff;
   assign sample_minutes = (in_minutes_ff > MAX_MINUTES) ? MAX_MINUTES : in_minutes_ff;

   // Decision logic for the item in the input register.
   always_comb begin
      mode_in          = mode_ff;
      cursor_in        = cursor_ff;
      hour_tens_in     = hour_tens_ff;
      hour_units_in    = hour_units_ff;
      minute_tens_in   = minute_tens_ff;
      minute_units_in  = minute_units_ff;
      alarm_hour_in    = alarm_hour_ff;
      alarm_minute_in  = alarm_minute_ff;
      alarm_enabled_in = alarm_enabled_ff;
      last_second_in   = last_second_ff;
      shown_hours_in   = shown_hours_ff;
      shown_minutes_in = shown_minutes_ff;
      edit_hours       = '0;
      edit_minutes     = '0;

      out_in               = '0;
      out_in.beep_code     = BEEP_NONE;

      case (op_type'(in_op_ff))
         OP_SAMPLE: begin
            // A new second in idle shows the time and checks the alarm.
            if (mode_ff == MODE_IDLE && in_seconds_ff != last_second_ff) begin
               last_second_in       = in_seconds_ff;
               shown_hours_in       = sample_hours;
               shown_minutes_in     = sample_minutes;
               out_in.display_word  = make_word(sample_hours, sample_minutes);
               out_in.display_valid = 1'b1;
               if (alarm_enabled_ff && sample_minutes == alarm_minute_ff &&
                   sample_hours == alarm_hour_ff) begin
                  out_in.beep_code = BEEP_ALARM;
               end
            end
         end
         OP_MENU: begin
            case (mode_ff)
               MODE_IDLE: begin
                  if (in_press_ff > long_limit_ff) begin
                     // Long press: alarm off.
                     alarm_enabled_in = 1'b0;
                     out_in.beep_code = BEEP_FOUR;
                  end else if (in_press_ff > short_limit_ff) begin
                     // Medium press: edit the alarm, starting from its time.
                     hour_tens_in         = hour_tens_of(alarm_hour_ff);
                     hour_units_in        = hour_units_of(alarm_hour_ff);
                     minute_tens_in       = minute_tens_of(alarm_minute_ff);
                     minute_units_in      = minute_units_of(alarm_minute_ff);
                     shown_hours_in       = alarm_hour_ff;
                     shown_minutes_in     = alarm_minute_ff;
                     last_second_in       = '0;
                     out_in.display_word  = make_word(alarm_hour_ff, alarm_minute_ff);
                     out_in.display_valid = 1'b1;
                     out_in.beep_code     = BEEP_TWO;
                     mode_in              = MODE_ALARM;
                  end else begin
                     // Short press: edit the time, starting from the shown time.
                     hour_tens_in     = hour_tens_of(shown_hours_ff);
                     hour_units_in    = hour_units_of(shown_hours_ff);
                     minute_tens_in   = minute_tens_of(shown_minutes_ff);
                     minute_units_in  = minute_units_of(shown_minutes_ff);
                     out_in.beep_code = BEEP_ONE;
                     mode_in          = MODE_TIME;
                  end
               end
               MODE_ALARM: begin
                  // Store and arm the alarm.
                  alarm_hour_in    = shown_hours_ff;
                  alarm_minute_in  = shown_minutes_ff;
                  alarm_enabled_in = 1'b1;
                  out_in.beep_code = BEEP_TWO;
                  mode_in          = MODE_IDLE;
               end
               default: begin
                  // Leave the time edit with a clock write, seconds at zero.
                  last_second_in       = '0;
                  out_in.rtc_write     = 1'b1;
                  out_in.set_hours     = shown_hours_ff;
                  out_in.set_minutes   = shown_minutes_ff;
                  out_in.display_word  = make_word(shown_hours_ff, shown_minutes_ff);
                  out_in.display_valid = 1'b1;
                  out_in.beep_code     = BEEP_ONE;
                  mode_in              = MODE_IDLE;
               end
            endcase
         end
         OP_NEXT: begin
            // Cursor steps over the four digits and wraps.
            if (mode_ff != MODE_IDLE) begin
               if (cursor_ff >= CURSOR_MIN_UNITS || cursor_ff < CURSOR_HOUR_TENS) begin
                  cursor_in = CURSOR_HOUR_TENS;
               end else begin
                  cursor_in = cursor_ff + 3'd1;
               end
            end
         end
         OP_INCREMENT, OP_DECREMENT: begin
            if (mode_ff != MODE_IDLE) begin
               if (op_type'(in_op_ff) == OP_INCREMENT) begin
                  case (cursor_ff)
                     CURSOR_HOUR_TENS: begin
                        if (hour_tens_ff < 2'd2) begin
                           hour_tens_in = hour_tens_ff + 2'd1;
                        end
                        if (hour_tens_in == 2'd2 && hour_units_ff > 4'd3) begin
                           hour_units_in = '0;
                        end
                     end
                     CURSOR_HOUR_UNITS: begin
                        if ((hour_tens_ff < 2'd2 && hour_units_ff < 4'd9) ||
                            (hour_tens_ff == 2'd2 && hour_units_ff < 4'd3)) begin
                           hour_units_in = hour_units_ff + 4'd1;
                        end
                     end
                     CURSOR_MIN_TENS: begin
                        if (minute_tens_ff < 3'd5) begin
                           minute_tens_in = minute_tens_ff + 3'd1;
                        end
                     end
                     CURSOR_MIN_UNITS: begin
                        if (minute_units_ff < 4'd9) begin
                           minute_units_in = minute_units_ff + 4'd1;
                        end
                     end
                     default: begin
                        hour_tens_in = hour_tens_ff;
                     end
                  endcase
               end else begin
                  case (cursor_ff)
                     CURSOR_HOUR_TENS: begin
                        if (hour_tens_ff != '0) hour_tens_in = hour_tens_ff - 2'd1;
                     end
                     CURSOR_HOUR_UNITS: begin
                        if (hour_units_ff != '0) hour_units_in = hour_units_ff - 4'd1;
                     end
                     CURSOR_MIN_TENS: begin
                        if (minute_tens_ff != '0) minute_tens_in = minute_tens_ff - 3'd1;
                     end
                     CURSOR_MIN_UNITS: begin
                        if (minute_units_ff != '0) begin
                           minute_units_in = minute_units_ff - 4'd1;
                        end
                     end
                     default: begin
                        hour_tens_in = hour_tens_ff;
                     end
                  endcase
               end
               // Time rebuilt from the edited digits.
               edit_hours   = {hour_tens_in, 3'b000} + {2'b00, hour_tens_in, 1'b0}
                              + {1'b0, hour_units_in};
               edit_minutes = {minute_tens_in, 3'b000} + {2'b00, minute_tens_in, 1'b0}
                              + {2'b00, minute_units_in};
               // Every digit change shows the edited time.
               shown_hours_in       = edit_hours;
               shown_minutes_in     = edit_minutes;
               last_second_in       = '0;
               out_in.display_word  = make_word(edit_hours, edit_minutes);
               out_in.display_valid = 1'b1;
            end
         end
         default: begin
            mode_in = mode_ff;
         end
      endcase

      out_in.edit_mode    = mode_code(mode_in);
      out_in.cursor_digit = cursor_in;
   end

   // Clock state, updated as an item moves into the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= MODE_IDLE;
         cursor_ff        <= CURSOR_HOUR_TENS;
         hour_tens_ff     <= '0;
         hour_units_ff    <= '0;
         minute_tens_ff   <= '0;
         minute_units_ff  <= '0;
         alarm_hour_ff    <= '0;
         alarm_minute_ff  <= '0;
         alarm_enabled_ff <= 1'b0;
         last_second_ff   <= '0;
         shown_hours_ff   <= 5'd22;
         shown_minutes_ff <= 6'd22;
      end else if (advance) begin
         mode_ff          <= mode_in;
         cursor_ff        <= cursor_in;
         hour_tens_ff     <= hour_tens_in;
         hour_units_ff    <= hour_units_in;
         minute_tens_ff   <= minute_tens_in;
         minute_units_ff  <= minute_units_in;
         alarm_hour_ff    <= alarm_hour_in;
         alarm_minute_ff  <= alarm_minute_in;
         alarm_enabled_ff <= alarm_enabled_in;
         last_second_ff   <= last_second_in;
         shown_hours_ff   <= shown_hours_in;
         shown_minutes_ff <= shown_minutes_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.display_word  = out_ff.display_word;
   assign rsp_chan.display_valid = out_ff.display_valid;
   assign rsp_chan.beep_code     = out_ff.beep_code;
   assign rsp_chan.rtc_write     = out_ff.rtc_write;
   assign rsp_chan.set_hours     = out_ff.set_hours;
   assign rsp_chan.set_minutes   = out_ff.set_minutes;
   assign rsp_chan.edit_mode     = out_ff.edit_mode;
   assign rsp_chan.cursor_digit  = out_ff.cursor_digit;

`ifndef NO_ASSERTIONS
   // The cursor always points at one of the four digits.
   assert property (@(posedge clock) disable iff (reset)
      cursor_ff >= CURSOR_HOUR_TENS && cursor_ff <= CURSOR_MIN_UNITS)
      else $error("cursor left the digit range");

   // The edit digits never describe a time beyond 23:59.
   assert property (@(posedge clock) disable iff (reset)
      hour_tens_ff <= 2'd2 && hour_units_ff <= 4'd9 && minute_tens_ff <= 3'd5 &&
      minute_units_ff <= 4'd9 && !(hour_tens_ff == 2'd2 && hour_units_ff > 4'd3))
      else $error("edit digits out of range");

   // A clock write always comes with the written time on display, in idle.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.rtc_write |->
         out_ff.display_valid && out_ff.edit_mode == EDIT_IDLE)
      else $error("clock write without display or outside idle");

   // A result without a display carries a zero word.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ff.display_valid |-> out_ff.display_word == '0)
      else $error("display word set without display valid");

   // An item that moves on leaves a result behind in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("item lost between input and result registers");
`endif

endmodule

`default_nettype wire
